### hdl/psre_pkg.sv
// Shared types, constants and helper functions of the stored-block PNG encoder.
package psre_pkg;

    localparam int CFG_W = 14;

    localparam logic [CFG_W-1:0] MAX_WIDTH  = 14'd8192;
    localparam logic [CFG_W-1:0] MAX_HEIGHT = 14'd8192;

    localparam logic [15:0] STORED_BLOCK_MAX = 16'd65535;
    localparam logic [16:0] ADLER_MOD        = 17'd65521;
    localparam logic [31:0] CRC_POLY         = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT         = 32'hFFFFFFFF;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [7:0] PNG_SIG [0:7] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                             8'd13, 8'd10, 8'd26, 8'd10};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DECIDE,
        ST_BLKHDR,
        ST_RAW,
        ST_TRAIL
    } state_t;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_PIX,
        SRC_WIDTH,
        SRC_HEIGHT,
        SRC_CRC,
        SRC_IDAT_LEN,
        SRC_BLK,
        SRC_ADLER
    } src_t;

    typedef struct packed {
        logic       emit;
        src_t       src;
        logic [2:0] pos;
        logic [7:0] cbyte;
        logic       crc_on;
        logic       crc_init;
        logic       run_last;
        logic       file_last;
        logic       pix_load;
        logic       frame_begin;
        logic       blk_set;
        logic       raw_step;
        logic       row_set;
        logic       frame_end;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic frame_open;
        logic row_zero;
        logic block_zero;
        logic raw_zero;
        logic raw_one;
    } stat_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] mx);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (v > mx)
            r = mx;
        else
            r = v;
        return r;
    endfunction

endpackage

### hdl/psre_datapath.sv
// Datapath: size registers, checksums, counters, byte selection and the output register.
module psre_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  psre_pkg::cmd_t               cmd,
    output psre_pkg::stat_t              stat,
    input  logic [7:0]                   pix_in,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [psre_pkg::CFG_W-1:0]   cfg_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);
    import psre_pkg::*;

    logic [CFG_W-1:0] cfg_w_reg, cfg_h_reg;
    logic [CFG_W-1:0] w_cl, h_cl;
    logic [15:0]      w4p1;
    logic [29:0]      raw_reg, raw_next;
    logic [13:0]      q;
    logic [16:0]      r, rr;
    logic             r_ge;
    logic [14:0]      nblk_reg, nblk_next;
    logic [31:0]      idat_reg, idat_next;

    logic [31:0]      crc_reg, crc_base, crc_new;
    logic [15:0]      adl_lo_reg, adl_hi_reg, lo_new, hi_new;
    logic [16:0]      lo_sum, hi_sum;
    logic [29:0]      raw_left_reg;
    logic [15:0]      block_left_reg, row_left_reg, len16;
    logic             blk_final;
    logic             frame_open_reg;
    logic [7:0]       pix_reg;

    logic [31:0]      word;
    logic [7:0]       out_byte;

    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic             m_last_reg, m_user_reg;

    assign w_cl = clamp_dim(cfg_w_reg, MAX_WIDTH);
    assign h_cl = clamp_dim(cfg_h_reg, MAX_HEIGHT);
    assign w4p1 = 16'({w_cl, 2'b00}) + 16'd1;
    assign raw_next = 30'(w4p1) * 30'(h_cl);

    // Block count is the raw size divided by 65535, rounded up; the remainder
    // of the shift form stays below twice the divisor.
    assign q    = raw_reg[29:16];
    assign r    = 17'(raw_reg[15:0]) + 17'(q);
    assign r_ge = (r >= 17'(STORED_BLOCK_MAX));
    assign rr   = r_ge ? (r - 17'(STORED_BLOCK_MAX)) : r;
    assign nblk_next = 15'(q) + 15'(r_ge) + 15'(rr != '0);
    assign idat_next = 32'(raw_reg) + 32'({nblk_reg, 2'b00}) + 32'(nblk_reg) + 32'd6;

    assign len16     = (raw_left_reg < 30'(STORED_BLOCK_MAX)) ? raw_left_reg[15:0]
                                                              : STORED_BLOCK_MAX;
    assign blk_final = (raw_left_reg <= 30'(STORED_BLOCK_MAX));

    always_comb
    begin
        case (cmd.src)
            SRC_WIDTH:    word = 32'(w_cl);
            SRC_HEIGHT:   word = 32'(h_cl);
            SRC_CRC:      word = ~crc_reg;
            SRC_IDAT_LEN: word = idat_reg;
            SRC_ADLER:    word = {adl_hi_reg, adl_lo_reg};
            default:      word = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.src)
            SRC_CONST: out_byte = cmd.cbyte;
            SRC_PIX:   out_byte = pix_reg;
            SRC_BLK:
            begin
                case (cmd.pos)
                    3'd0:    out_byte = {7'd0, blk_final};
                    3'd1:    out_byte = len16[7:0];
                    3'd2:    out_byte = len16[15:8];
                    3'd3:    out_byte = ~len16[7:0];
                    default: out_byte = ~len16[15:8];
                endcase
            end
            default:
            begin
                case (cmd.pos[1:0])
                    2'd0:    out_byte = word[31:24];
                    2'd1:    out_byte = word[23:16];
                    2'd2:    out_byte = word[15:8];
                    default: out_byte = word[7:0];
                endcase
            end
        endcase
    end

    assign crc_base = cmd.crc_init ? CRC_INIT : crc_reg;
    assign crc_new  = crc_byte(crc_base, out_byte);

    assign lo_sum = 17'(adl_lo_reg) + 17'(out_byte);
    assign lo_new = (lo_sum >= ADLER_MOD) ? 16'(lo_sum - ADLER_MOD) : lo_sum[15:0];
    assign hi_sum = 17'(adl_hi_reg) + 17'(lo_new);
    assign hi_new = (hi_sum >= ADLER_MOD) ? 16'(hi_sum - ADLER_MOD) : hi_sum[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg      <= CFG_W'(1);
            cfg_h_reg      <= CFG_W'(1);
            crc_reg        <= CRC_INIT;
            adl_lo_reg     <= 16'd1;
            adl_hi_reg     <= 16'd0;
            raw_left_reg   <= '0;
            block_left_reg <= '0;
            row_left_reg   <= '0;
            frame_open_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && !frame_open_reg)
            begin
                if (cfg_index == CFG_IDX_WIDTH)
                    cfg_w_reg <= cfg_data;
                else
                    cfg_h_reg <= cfg_data;
            end

            if (cmd.emit && cmd.crc_on)
                crc_reg <= crc_new;

            if (cmd.frame_begin)
            begin
                adl_lo_reg     <= 16'd1;
                adl_hi_reg     <= 16'd0;
                raw_left_reg   <= raw_reg;
                block_left_reg <= '0;
                row_left_reg   <= '0;
                frame_open_reg <= 1'b1;
            end

            if (cmd.blk_set)
                block_left_reg <= len16;

            if (cmd.raw_step)
            begin
                adl_lo_reg     <= lo_new;
                adl_hi_reg     <= hi_new;
                block_left_reg <= block_left_reg - 16'd1;
                raw_left_reg   <= raw_left_reg - 30'd1;
                if (cmd.row_set)
                    row_left_reg <= (raw_left_reg == 30'd1) ? 16'd0 : 16'({w_cl, 2'b00});
                else
                    row_left_reg <= row_left_reg - 16'd1;
            end

            if (cmd.frame_end)
            begin
                frame_open_reg <= 1'b0;
                crc_reg        <= CRC_INIT;
                row_left_reg   <= '0;
                block_left_reg <= '0;
            end

            if (cmd.emit)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        nblk_reg <= nblk_next;
        idat_reg <= idat_next;
        if (cmd.pix_load)
            pix_reg <= pix_in;
        if (cmd.emit)
        begin
            m_data_reg <= out_byte;
            m_last_reg <= cmd.run_last;
            m_user_reg <= cmd.file_last;
        end
    end

    assign stat.out_free   = !m_valid_reg || m_tready;
    assign stat.frame_open = frame_open_reg;
    assign stat.row_zero   = (row_left_reg == '0);
    assign stat.block_zero = (block_left_reg == '0);
    assign stat.raw_zero   = (raw_left_reg == '0);
    assign stat.raw_one    = (raw_left_reg == 30'd1);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

### hdl/psre_ctrl.sv
// Controller: sequences header, block header, raw byte and trailer output.
module psre_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_tuser,
    input  psre_pkg::stat_t  stat,
    output psre_pkg::cmd_t   cmd
);
    import psre_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] idx_reg, idx_next, rel;
    logic       filt_reg, filt_next;
    logic       acc;

    assign acc = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            filt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            filt_reg  <= filt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        filt_next  = filt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (acc)
                begin
                    if (!s_tuser)
                        state_next = ST_START;
                    else if (stat.frame_open)
                    begin
                        state_next = ST_DECIDE;
                        filt_next  = stat.row_zero;
                    end
                end
            end
            ST_START:
            begin
                if (stat.out_free)
                begin
                    if (idx_reg == 6'd42)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end
                    else
                        idx_next = idx_reg + 6'd1;
                end
            end
            ST_DECIDE:
            begin
                idx_next = '0;
                if (!filt_reg && stat.raw_zero)
                    state_next = ST_TRAIL;
                else if (stat.block_zero)
                    state_next = ST_BLKHDR;
                else
                    state_next = ST_RAW;
            end
            ST_BLKHDR:
            begin
                if (stat.out_free)
                begin
                    if (idx_reg == 6'd4)
                    begin
                        state_next = ST_RAW;
                        idx_next   = '0;
                    end
                    else
                        idx_next = idx_reg + 6'd1;
                end
            end
            ST_RAW:
            begin
                if (stat.out_free)
                begin
                    idx_next = '0;
                    if (filt_reg)
                    begin
                        filt_next  = 1'b0;
                        state_next = ST_DECIDE;
                    end
                    else if (stat.raw_one)
                        state_next = ST_TRAIL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_TRAIL:
            begin
                if (stat.out_free)
                begin
                    if (idx_reg == 6'd19)
                    begin
                        state_next = ST_IDLE;
                        idx_next   = '0;
                    end
                    else
                        idx_next = idx_reg + 6'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        rel      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.pix_load = s_tvalid;
            end
            ST_START:
            begin
                cmd.emit = stat.out_free;
                cmd.src  = SRC_CONST;
                if (idx_reg < 6'd8)
                    cmd.cbyte = PNG_SIG[idx_reg[2:0]];
                else if (idx_reg == 6'd11)
                    cmd.cbyte = 8'd13;
                else if (idx_reg >= 6'd16 && idx_reg <= 6'd19)
                begin
                    cmd.src = SRC_WIDTH;
                    cmd.pos = {1'b0, idx_reg[1:0]};
                end
                else if (idx_reg >= 6'd20 && idx_reg <= 6'd23)
                begin
                    cmd.src = SRC_HEIGHT;
                    cmd.pos = {1'b0, idx_reg[1:0]};
                end
                else if (idx_reg >= 6'd29 && idx_reg <= 6'd32)
                begin
                    rel     = idx_reg - 6'd29;
                    cmd.src = SRC_CRC;
                    cmd.pos = rel[2:0];
                end
                else if (idx_reg >= 6'd33 && idx_reg <= 6'd36)
                begin
                    rel     = idx_reg - 6'd33;
                    cmd.src = SRC_IDAT_LEN;
                    cmd.pos = rel[2:0];
                end
                else
                begin
                    case (idx_reg)
                        6'd12:   cmd.cbyte = 8'd73;
                        6'd13:   cmd.cbyte = 8'd72;
                        6'd14:   cmd.cbyte = 8'd68;
                        6'd15:   cmd.cbyte = 8'd82;
                        6'd24:   cmd.cbyte = 8'd8;
                        6'd25:   cmd.cbyte = 8'd6;
                        6'd37:   cmd.cbyte = 8'd73;
                        6'd38:   cmd.cbyte = 8'd68;
                        6'd39:   cmd.cbyte = 8'd65;
                        6'd40:   cmd.cbyte = 8'd84;
                        6'd41:   cmd.cbyte = 8'd120;
                        6'd42:   cmd.cbyte = 8'd1;
                        default: cmd.cbyte = 8'd0;
                    endcase
                end
                cmd.crc_on = (idx_reg >= 6'd12 && idx_reg <= 6'd28) || (idx_reg >= 6'd37);
                cmd.crc_init    = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                cmd.run_last    = (idx_reg == 6'd42);
                cmd.frame_begin = stat.out_free && (idx_reg == 6'd42);
            end
            ST_DECIDE:
            begin
                cmd.emit = 1'b0;
            end
            ST_BLKHDR:
            begin
                cmd.emit    = stat.out_free;
                cmd.src     = SRC_BLK;
                cmd.pos     = idx_reg[2:0];
                cmd.crc_on  = 1'b1;
                cmd.blk_set = stat.out_free && (idx_reg == 6'd4);
            end
            ST_RAW:
            begin
                cmd.emit     = stat.out_free;
                cmd.src      = filt_reg ? SRC_CONST : SRC_PIX;
                cmd.crc_on   = 1'b1;
                cmd.raw_step = stat.out_free;
                cmd.row_set  = filt_reg;
                cmd.run_last = !filt_reg && !stat.raw_one;
            end
            ST_TRAIL:
            begin
                cmd.emit = stat.out_free;
                cmd.src  = SRC_CONST;
                if (idx_reg <= 6'd3)
                begin
                    cmd.src    = SRC_ADLER;
                    cmd.pos    = {1'b0, idx_reg[1:0]};
                    cmd.crc_on = 1'b1;
                end
                else if (idx_reg <= 6'd7 || idx_reg >= 6'd16)
                begin
                    cmd.src = SRC_CRC;
                    cmd.pos = {1'b0, idx_reg[1:0]};
                end
                else
                begin
                    case (idx_reg)
                        6'd12:   cmd.cbyte = 8'd73;
                        6'd13:   cmd.cbyte = 8'd69;
                        6'd14:   cmd.cbyte = 8'd78;
                        6'd15:   cmd.cbyte = 8'd68;
                        default: cmd.cbyte = 8'd0;
                    endcase
                    cmd.crc_on = (idx_reg >= 6'd12);
                end
                cmd.crc_init  = (idx_reg == 6'd12);
                cmd.run_last  = (idx_reg == 6'd19);
                cmd.file_last = (idx_reg == 6'd19);
                cmd.frame_end = stat.out_free && (idx_reg == 6'd19);
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

### hdl/png_stored_rgba_encoder_core.sv
// Requests are taken only when idle: a new one waits until all bytes of the last are issued.
// Header and trailer bytes leave at one byte per cycle unless stalled. A start request gives
// 43 bytes, a pixel request up to 26 (none with no frame open): its byte, a filter byte at a
// row start, a block header per block and the trailer, all through a single output register.
// Reset (rst_n, asynchronous, active low) closes any frame and sets both sizes to one.
// Size writes are ignored while a frame is open.
module png_stored_rgba_encoder_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // pixel_byte
    input  logic                         s_tuser,   // req_type
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // out_byte
    output logic                         m_tlast,   // run_last
    output logic                         m_tuser,   // file_last
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [psre_pkg::CFG_W-1:0]   cfg_data
);
    import psre_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    psre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    psre_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .pix_in    (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

### sim/psre_test_pkg.sv
// Request kinds shared by the encoder testbench modules.
`timescale 1ns / 100ps
package psre_test_pkg;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_PIXEL = 1'b1
    } req_kind_t;

endpackage

### sim/png_stream_checker.sv
// Predicts the PNG byte stream from observed requests and compares it with the encoder output.
`timescale 1ns / 100ps
module png_stream_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [13:0] cfg_data,
    output int          failures,
    output int          pending
);
    import psre_test_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       file_last;
    } file_byte_t;

    file_byte_t file_bytes[$];

    logic [13:0] width_reg;
    logic [13:0] height_reg;
    logic [31:0] crc_run;
    int          adler_a;
    int          adler_b;
    longint      raw_remaining;
    int          block_remaining;
    int          row_remaining;
    bit          frame_active;

    assign pending = file_bytes.size();

    function automatic logic [31:0] crc_next(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int dim_used(input logic [13:0] v);
        if (v == 0)
            return 1;
        return (v > 8192) ? 8192 : int'(v);
    endfunction

    task automatic put_byte(input logic [7:0] b, input bit in_crc);
        file_byte_t fb;
        fb.data = b;
        fb.run_last = 1'b0;
        fb.file_last = 1'b0;
        file_bytes = {file_bytes, fb};
        if (in_crc)
            crc_run = crc_next(crc_run, b);
    endtask

    task automatic put_word(input logic [31:0] v, input bit in_crc);
        for (int i = 3; i >= 0; i--)
        begin
            put_byte(v[i*8 +: 8], in_crc);
        end
    endtask

    // A chunk type restarts the CRC and is itself covered by it.
    task automatic put_chunk_type(input logic [31:0] tag);
        crc_run = 32'hFFFFFFFF;
        put_word(tag, 1'b1);
    endtask

    task automatic put_raw(input logic [7:0] v);
        int len;
        if (block_remaining == 0)
        begin
            len = (raw_remaining < 65535) ? int'(raw_remaining) : 65535;
            put_byte((longint'(len) == raw_remaining) ? 8'd1 : 8'd0, 1'b1);
            put_byte(len[7:0], 1'b1);
            put_byte(len[15:8], 1'b1);
            put_byte(~len[7:0], 1'b1);
            put_byte(~len[15:8], 1'b1);
            block_remaining = len;
        end
        put_byte(v, 1'b1);
        adler_a = (adler_a + v) % 65521;
        adler_b = (adler_b + adler_a) % 65521;
        block_remaining--;
        raw_remaining--;
    endtask

    task automatic open_frame();
        int w;
        int h;
        longint raw;
        longint blocks;
        logic [31:0] idat_len;
        w = dim_used(width_reg);
        h = dim_used(height_reg);
        raw = (longint'(w) * 4 + 1) * h;
        blocks = (raw + 65534) / 65535;
        idat_len = 32'(2 + raw + 5 * blocks + 4);
        put_word(32'h89504E47, 1'b0);
        put_word(32'h0D0A1A0A, 1'b0);
        put_word(32'd13, 1'b0);
        put_chunk_type(32'h49484452);
        put_word(32'(w), 1'b1);
        put_word(32'(h), 1'b1);
        put_byte(8'd8, 1'b1);
        put_byte(8'd6, 1'b1);
        put_byte(8'd0, 1'b1);
        put_byte(8'd0, 1'b1);
        put_byte(8'd0, 1'b1);
        put_word(~crc_run, 1'b0);
        put_word(idat_len, 1'b0);
        put_chunk_type(32'h49444154);
        put_byte(8'd120, 1'b1);
        put_byte(8'd1, 1'b1);
        adler_a = 1;
        adler_b = 0;
        raw_remaining = raw;
        block_remaining = 0;
        row_remaining = 0;
        frame_active = 1'b1;
    endtask

    task automatic add_pixel(input logic [7:0] v);
        if (row_remaining == 0)
        begin
            put_raw(8'd0);
            row_remaining = (raw_remaining == 0) ? 0 : dim_used(width_reg) * 4;
        end
        if (raw_remaining != 0)
        begin
            put_raw(v);
            row_remaining--;
        end
        if (raw_remaining == 0)
        begin
            put_word({adler_b[15:0], adler_a[15:0]}, 1'b1);
            put_word(~crc_run, 1'b0);
            put_word(32'd0, 1'b0);
            put_chunk_type(32'h49454E44);
            put_word(~crc_run, 1'b0);
            file_bytes[file_bytes.size()-1].file_last = 1'b1;
            frame_active = 1'b0;
            crc_run = 32'hFFFFFFFF;
            row_remaining = 0;
            block_remaining = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 14'd1;
            height_reg <= 14'd1;
            crc_run <= 32'hFFFFFFFF;
            adler_a <= 1;
            adler_b <= 0;
            raw_remaining <= 0;
            block_remaining <= 0;
            row_remaining <= 0;
            frame_active <= 1'b0;
            failures <= 0;
        end
        else
        begin
            // Size writes are dropped while a frame is open.
            if (cfg_we && !frame_active)
            begin
                if (cfg_index == psre_pkg::CFG_IDX_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                int before_n;
                before_n = file_bytes.size();
                if (s_tuser == REQ_START)
                    open_frame();
                else if (frame_active)
                    add_pixel(s_tdata);
                if (file_bytes.size() > before_n)
                    file_bytes[file_bytes.size()-1].run_last = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                file_byte_t want;
                if (file_bytes.size() == 0)
                begin
                    $error("unexpected output byte %0d", m_tdata);
                    failures = failures + 1;
                end
                else
                begin
                    want = file_bytes.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("out_byte expected %0d actual %0d", want.data, m_tdata);
                        failures = failures + 1;
                    end
                    if (m_tlast !== want.run_last)
                    begin
                        $error("run_last expected %0d actual %0d", want.run_last, m_tlast);
                        failures = failures + 1;
                    end
                    if (m_tuser !== want.file_last)
                    begin
                        $error("file_last expected %0d actual %0d", want.file_last, m_tuser);
                        failures = failures + 1;
                    end
                end
            end
        end
    end

endmodule

### sim/png_stored_rgba_encoder_core_test.sv
// Testbench top: drives requests, size writes and output stalls, and gives the verdict.
`timescale 1ns / 100ps
module png_stored_rgba_encoder_core_test;
    import psre_test_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [13:0] cfg_data = 14'd0;
    int          failures;
    int          pending;
    int          requests_sent = 0;
    int          stall_left = 0;
    bit          stalls_on = 1'b1;

    png_stored_rgba_encoder_core uut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    png_stream_checker checker_i
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .pending(pending)
    );

    always #5 clk = ~clk;

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: long stretches without stalls alternate with random stalls.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            stalls_on <= ~stalls_on;
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (stalls_on)
                stall_left <= gap_cycles();
        end
    end

    task automatic send_request(input req_kind_t kind, input logic [7:0] data);
        int g;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= data;
        do
            @(posedge clk);
        while (!s_tready);
        requests_sent++;
        g = gap_cycles();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Waits for the stream to drain, plus slack for a pixel request that gives no output.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_size(input logic idx, input logic [13:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixels(input int n);
        for (int i = 0; i < n; i++)
        begin
            send_request(REQ_PIXEL, 8'($urandom));
        end
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // A pixel with no frame open is dropped; then the default one-pixel frame.
        send_request(REQ_PIXEL, 8'hFF);
        settle();
        send_request(REQ_START, 8'hFF);
        send_request(REQ_PIXEL, 8'h00);
        send_request(REQ_PIXEL, 8'hFF);
        send_request(REQ_PIXEL, 8'h5A);
        send_request(REQ_PIXEL, 8'hA5);
        settle();

        // Zero sizes are used as one; a size write during an open frame is dropped.
        write_size(psre_pkg::CFG_IDX_WIDTH, 14'd0);
        write_size(psre_pkg::CFG_IDX_HEIGHT, 14'd0);
        send_request(REQ_START, 8'h00);
        send_pixels(2);
        settle();
        write_size(psre_pkg::CFG_IDX_WIDTH, 14'd5);
        send_pixels(2);
        settle();

        // A start in the middle of a frame abandons it.
        write_size(psre_pkg::CFG_IDX_WIDTH, 14'd2);
        send_request(REQ_START, 8'h00);
        send_pixels(3);
        send_request(REQ_START, 8'h00);
        send_pixels(8);
        settle();

        while (requests_sent < 225)
        begin
            w = $urandom_range(0, 3);
            h = $urandom_range(1, 3);
            write_size(psre_pkg::CFG_IDX_WIDTH, 14'(w));
            write_size(psre_pkg::CFG_IDX_HEIGHT, 14'(h));
            n = ((w == 0) ? 1 : w) * 4 * h;
            if ($urandom_range(0, 7) == 0)
                send_request(REQ_PIXEL, 8'($urandom));
            send_request(REQ_START, 8'($urandom));
            if ($urandom_range(0, 5) == 0)
            begin
                send_pixels($urandom_range(1, n - 1));
                send_request(REQ_START, 8'($urandom));
            end
            send_pixels(n);
            settle();
        end

        // Oversized values saturate; this frame spans many stored blocks and is left open.
        write_size(psre_pkg::CFG_IDX_WIDTH, 14'h3FFF);
        write_size(psre_pkg::CFG_IDX_HEIGHT, 14'h3FFF);
        send_request(REQ_START, 8'h00);
        send_pixels(40);
        settle();
        repeat (20) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
